>>> src/dncr_pkg.sv
package dncr_pkg;

  localparam int DEF_RANDOM_BYTES = 32;

  localparam logic [3:0] HEADER_LEN = 4'd12;
  localparam logic [3:0] QDCOUNT_HI = 4'd4;
  localparam logic [3:0] QDCOUNT_LO = 4'd5;
  localparam logic [7:0] MAX_LABEL  = 8'd63;
  localparam logic [2:0] TAIL_NEED  = 3'd4;
  localparam logic [7:0] CASE_DIFF  = 8'd32;

  localparam logic [7:0] UPPER_A = 8'h41;
  localparam logic [7:0] UPPER_Z = 8'h5a;
  localparam logic [7:0] LOWER_A = 8'h61;
  localparam logic [7:0] LOWER_Z = 8'h7a;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_LABEL,
    PH_TAIL,
    PH_ERROR
  } phase_t;

  typedef struct packed {
    logic load;
    logic load_last;
    logic take;
    logic pkt_end;
  } rnd_ctl_t;

endpackage

>>> src/dncr_rand_store.sv
module dncr_rand_store
  import dncr_pkg::*;
#(
  parameter int RANDOM_BYTES = DEF_RANDOM_BYTES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  rnd_ctl_t   ctl,
  input  logic [7:0] wr_data,
  output logic       rnd_bit,
  output logic       exhausted
);

  localparam int AW = (RANDOM_BYTES > 1) ? $clog2(RANDOM_BYTES) : 1;
  localparam int BW = $clog2(RANDOM_BYTES * 8 + 1);
  localparam int IW = BW - 3;
  localparam logic [BW-1:0] BITS_TOTAL = BW'(RANDOM_BYTES * 8);
  localparam logic [IW:0]   RB_I       = (IW + 1)'(RANDOM_BYTES);
  localparam logic [AW:0]   RB_A       = (AW + 1)'(RANDOM_BYTES);

  logic [7:0] mem [RANDOM_BYTES];

  logic [BW-1:0] bits_used_r, bits_used_nxt;
  logic [AW-1:0] load_ptr_r, load_ptr_nxt;
  logic          byp_r, byp_nxt;
  logic [7:0]    byp_data_r;
  logic [7:0]    rd_r;
  logic [7:0]    cur_r, cur_nxt;
  logic [7:0]    zero_r, zero_nxt;

  logic [IW-1:0] idx, idx_nxt;
  logic [IW:0]   ahead_idx;
  logic [AW-1:0] rd_addr;
  logic [AW:0]   ptr_inc;
  logic [7:0]    ahead;

  assign idx       = bits_used_r[BW-1:3];
  assign idx_nxt   = bits_used_nxt[BW-1:3];
  assign ahead_idx = {1'b0, idx_nxt} + 1'b1;
  assign rd_addr   = (ahead_idx < RB_I) ? ahead_idx[AW-1:0] : '0;
  assign ahead     = byp_r ? byp_data_r : rd_r;
  assign ptr_inc   = {1'b0, load_ptr_r} + 1'b1;

  assign rnd_bit   = cur_r[bits_used_r[2:0]];
  assign exhausted = (bits_used_r >= BITS_TOTAL);

  always_comb begin
    bits_used_nxt = bits_used_r;
    if (ctl.pkt_end) begin
      bits_used_nxt = '0;
    end else if (ctl.take) begin
      bits_used_nxt = bits_used_r + 1'b1;
    end

    load_ptr_nxt = load_ptr_r;
    if (ctl.pkt_end) begin
      load_ptr_nxt = '0;
    end else if (ctl.load) begin
      if (ctl.load_last || ptr_inc >= RB_A) begin
        load_ptr_nxt = '0;
      end else begin
        load_ptr_nxt = ptr_inc[AW-1:0];
      end
    end

    byp_nxt = ctl.load && (load_ptr_r == rd_addr);

    zero_nxt = zero_r;
    if (ctl.load && load_ptr_r == '0) begin
      zero_nxt = wr_data;
    end

    cur_nxt = cur_r;
    if (ctl.load && idx == IW'(load_ptr_r)) begin
      cur_nxt = wr_data;
    end else if (idx_nxt != idx) begin
      cur_nxt = ctl.pkt_end ? zero_r : ahead;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_used_r <= '0;
      load_ptr_r  <= '0;
      byp_r       <= 1'b0;
    end else begin
      bits_used_r <= bits_used_nxt;
      load_ptr_r  <= load_ptr_nxt;
      byp_r       <= byp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= wr_data;
    cur_r      <= cur_nxt;
    zero_r     <= zero_nxt;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mem[load_ptr_r] <= wr_data;
    end
    rd_r <= mem[rd_addr];
  end

endmodule

>>> src/dncr_parser.sv
module dncr_parser
  import dncr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       rnd_bit,
  input  logic       exhausted,
  output logic       take,
  output logic [7:0] res_byte,
  output logic       res_status
);

  phase_t     phase_r, phase_nxt;
  logic [3:0] hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0] cnt_hi_r, cnt_hi_nxt;
  logic [5:0] label_left_r, label_left_nxt;
  logic [2:0] tail_cnt_r, tail_cnt_nxt;

  logic [7:0] low;
  logic       is_letter;
  logic [3:0] hdr_inc;
  logic [5:0] label_dec;

  assign low       = (data_byte >= UPPER_A && data_byte <= UPPER_Z) ?
                     data_byte + CASE_DIFF : data_byte;
  assign is_letter = (low >= LOWER_A && low <= LOWER_Z);
  assign hdr_inc   = hdr_cnt_r + 1'b1;
  assign label_dec = label_left_r - 1'b1;

  always_comb begin
    phase_nxt      = phase_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    cnt_hi_nxt     = cnt_hi_r;
    label_left_nxt = label_left_r;
    tail_cnt_nxt   = tail_cnt_r;
    res_byte       = data_byte;
    take           = 1'b0;

    case (phase_r)
      PH_HEADER: begin
        if (hdr_cnt_r == QDCOUNT_HI) begin
          cnt_hi_nxt = data_byte;
        end
        if (hdr_cnt_r == QDCOUNT_LO && !(cnt_hi_r == 8'd0 && data_byte == 8'd1)) begin
          phase_nxt = PH_ERROR;
        end else begin
          hdr_cnt_nxt = hdr_inc;
          if (hdr_inc >= HEADER_LEN) begin
            phase_nxt = PH_LENGTH;
          end
        end
      end
      PH_LENGTH: begin
        if (data_byte == 8'd0) begin
          phase_nxt    = PH_TAIL;
          tail_cnt_nxt = '0;
        end else if (data_byte > MAX_LABEL) begin
          phase_nxt = PH_ERROR;
        end else begin
          label_left_nxt = data_byte[5:0];
          phase_nxt      = PH_LABEL;
        end
      end
      PH_LABEL: begin
        if (is_letter && exhausted) begin
          phase_nxt = PH_ERROR;
        end else begin
          if (is_letter) begin
            take     = step;
            res_byte = rnd_bit ? low - CASE_DIFF : low;
          end
          label_left_nxt = label_dec;
          if (label_dec == '0) begin
            phase_nxt = PH_LENGTH;
          end
        end
      end
      PH_TAIL: begin
        if (tail_cnt_r < TAIL_NEED) begin
          tail_cnt_nxt = tail_cnt_r + 1'b1;
        end
      end
      default: begin
      end
    endcase

    res_status = last_byte && !(phase_nxt == PH_TAIL && tail_cnt_nxt >= TAIL_NEED);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      hdr_cnt_r    <= '0;
      cnt_hi_r     <= '0;
      label_left_r <= '0;
      tail_cnt_r   <= '0;
    end else if (step) begin
      if (last_byte) begin
        phase_r      <= PH_HEADER;
        hdr_cnt_r    <= '0;
        cnt_hi_r     <= '0;
        label_left_r <= '0;
        tail_cnt_r   <= '0;
      end else begin
        phase_r      <= phase_nxt;
        hdr_cnt_r    <= hdr_cnt_nxt;
        cnt_hi_r     <= cnt_hi_nxt;
        label_left_r <= label_left_nxt;
        tail_cnt_r   <= tail_cnt_nxt;
      end
    end
  end

endmodule

>>> src/dns_name_case_randomizer.sv
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall  | in_mode, in_data_byte, in_last_byte
// out     | output    | out_valid / out_stall| out_byte, out_last, out_status
//
// One item per cycle unless out_stall holds a packet item: an item goes from the
// input register via the parser to the result register; store loads yield no item.
// The random store keeps its next entry prefetched, so letters recase back to back.
// Reset (rst_n low, synchronous) clears parser state and both handshake registers;
// store contents stay undefined until loaded.
// out_stall holds a packet item in the input register; store loads still drain.
module dns_name_case_randomizer
  import dncr_pkg::*;
#(
  parameter int RANDOM_BYTES = DEF_RANDOM_BYTES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_status
);

  logic       in_v_r, in_v_nxt;
  logic       mode_r;
  logic [7:0] data_r;
  logic       last_r;

  logic       out_v_r, out_v_nxt;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       out_status_r;

  logic       adv;
  logic       step;
  logic       in_acc;
  logic       take;
  logic       rnd_bit;
  logic       exhausted;
  logic [7:0] res_byte;
  logic       res_status;
  rnd_ctl_t   ctl;

  assign adv      = in_v_r && (!mode_r || !out_v_r || !out_stall);
  assign step     = adv && mode_r;
  assign in_stall = in_v_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  assign ctl.load      = adv && !mode_r;
  assign ctl.load_last = last_r;
  assign ctl.take      = take;
  assign ctl.pkt_end   = step && last_r;

  dncr_rand_store #(
    .RANDOM_BYTES(RANDOM_BYTES)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .wr_data   (data_r),
    .rnd_bit   (rnd_bit),
    .exhausted (exhausted)
  );

  dncr_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .data_byte  (data_r),
    .last_byte  (last_r),
    .rnd_bit    (rnd_bit),
    .exhausted  (exhausted),
    .take       (take),
    .res_byte   (res_byte),
    .res_status (res_status)
  );

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_acc) begin
      in_v_nxt = 1'b1;
    end else if (adv) begin
      in_v_nxt = 1'b0;
    end

    out_v_nxt = out_v_r;
    if (step) begin
      out_v_nxt = 1'b1;
    end else if (out_v_r && !out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_mode;
      data_r <= in_data_byte;
      last_r <= in_last_byte;
    end
    if (step) begin
      out_byte_r   <= res_byte;
      out_last_r   <= last_r;
      out_status_r <= res_status;
    end
  end

  assign out_valid  = out_v_r;
  assign out_byte   = out_byte_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

endmodule

>>> tb/dns_name_case_randomizer_test.sv
module dns_name_case_randomizer_test
  import dncr_pkg::*;
();

  localparam int STORE_BYTES = DEF_RANDOM_BYTES;
  localparam int RANDOM_ITEMS = 120;
  localparam int CALM_ITEMS = 40;
  localparam int STALL_LIMIT = 2000;
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_PACKET = 1'b1;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       status;
  } dns_out_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_mode = 1'b0;
  logic [7:0] in_data_byte = 8'd0;
  logic       in_last_byte = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_status;

  dns_name_case_randomizer i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .out_status   (out_status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [7:0] rnd_store [STORE_BYTES];
  int         rnd_load_ptr = 0;
  logic [3:0] hdr_seen = 4'd0;
  logic [7:0] qd_high = 8'd0;
  phase_t     name_phase = PH_HEADER;
  logic [5:0] label_rem = 6'd0;
  int         case_bits_taken = 0;
  logic [2:0] tail_seen = 3'd0;

  dns_out_t   bytes_due [$];
  logic [7:0] pkt_bytes [$];
  int         errors = 0;
  int         items_sent = 0;
  int         tx_gap_pct = 0;
  int         letter_pct = 50;
  logic       rx_stalls = 1'b0;
  logic       mix_loads = 1'b0;
  logic       calm = 1'b0;
  int         stall_hold = 0;
  int         quiet_cycles = 0;

  function automatic logic [7:0] recase_letter(input logic [7:0] b);
    logic [7:0] low;
    logic       rbit;
    low = b;
    if (b >= UPPER_A && b <= UPPER_Z) low = b + CASE_DIFF;
    if (low < LOWER_A || low > LOWER_Z) return b;
    if (case_bits_taken >= STORE_BYTES * 8) begin
      name_phase = PH_ERROR;
      return b;
    end
    rbit = rnd_store[case_bits_taken / 8][case_bits_taken % 8];
    case_bits_taken++;
    return rbit ? low - CASE_DIFF : low;
  endfunction

  function automatic logic [7:0] parse_name_byte(input logic [7:0] b);
    logic [7:0] o;
    o = b;
    case (name_phase)
      PH_HEADER: begin
        if (hdr_seen == QDCOUNT_HI) qd_high = b;
        if (hdr_seen == QDCOUNT_LO && !(qd_high == 8'd0 && b == 8'd1)) begin
          name_phase = PH_ERROR;
        end else begin
          hdr_seen++;
          if (hdr_seen >= HEADER_LEN) name_phase = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        if (b == 8'd0) begin
          name_phase = PH_TAIL;
          tail_seen = 3'd0;
        end else if (b > MAX_LABEL) begin
          name_phase = PH_ERROR;
        end else begin
          label_rem = b[5:0];
          name_phase = PH_LABEL;
        end
      end
      PH_LABEL: begin
        o = recase_letter(b);
        if (name_phase != PH_ERROR) begin
          label_rem--;
          if (label_rem == 6'd0) name_phase = PH_LENGTH;
        end
      end
      PH_TAIL: begin
        if (tail_seen < TAIL_NEED) tail_seen++;
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic predict_dns_item(input logic mode, input logic [7:0] b, input logic last);
    dns_out_t r;
    if (mode == MODE_LOAD) begin
      rnd_store[rnd_load_ptr] = b;
      if (last || rnd_load_ptr + 1 >= STORE_BYTES) rnd_load_ptr = 0;
      else rnd_load_ptr++;
    end else begin
      r.data = parse_name_byte(b);
      r.last = last;
      r.status = 1'b0;
      if (last) begin
        r.status = !(name_phase == PH_TAIL && tail_seen >= TAIL_NEED);
        rnd_load_ptr = 0;
        hdr_seen = 4'd0;
        qd_high = 8'd0;
        name_phase = PH_HEADER;
        label_rem = 6'd0;
        case_bits_taken = 0;
        tail_seen = 3'd0;
      end
      bytes_due.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    dns_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (bytes_due.size() == 0) begin
        $error("unexpected result item: out_byte %h out_last %b", out_byte, out_last);
        errors++;
      end else begin
        want = bytes_due.pop_front();
        if (out_byte !== want.data) begin
          $error("out_byte: expected %h, got %h", want.data, out_byte);
          errors++;
        end
        if (out_last !== want.last) begin
          $error("out_last: expected %b, got %b", want.last, out_last);
          errors++;
        end
        if (out_status !== want.status) begin
          $error("out_status: expected %b, got %b", want.status, out_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (calm) begin
      out_stall <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall <= rx_stalls && ($urandom_range(0, 1) == 1);
      stall_hold <= $urandom_range(0, 10);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic mode, input logic [7:0] b, input logic last);
    if (!calm && tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_dns_item(mode, b, last);
    items_sent++;
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1) == 1) return 8'($urandom_range(UPPER_A, UPPER_Z));
    return 8'($urandom_range(LOWER_A, LOWER_Z));
  endfunction

  task automatic start_packet(input logic [7:0] hi, input logic [7:0] lo);
    pkt_bytes.delete();
    for (int i = 0; i < HEADER_LEN; i++) begin
      pkt_bytes.push_back(i == QDCOUNT_HI ? hi : i == QDCOUNT_LO ? lo : 8'($urandom));
    end
  endtask

  task automatic add_label(input int len);
    pkt_bytes.push_back(8'(len));
    for (int i = 0; i < len; i++) begin
      pkt_bytes.push_back($urandom_range(0, 99) < letter_pct ? rand_letter() : 8'($urandom));
    end
  endtask

  task automatic add_tail(input int n);
    pkt_bytes.push_back(8'd0);
    repeat (n) pkt_bytes.push_back(8'($urandom));
  endtask

  task automatic cut_packet(input int n);
    while (pkt_bytes.size() > n) void'(pkt_bytes.pop_back());
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt_bytes.size(); i++) begin
      if (mix_loads && $urandom_range(0, 24) == 0) begin
        send_item(MODE_LOAD, 8'($urandom), 1'($urandom_range(0, 1)));
      end
      send_item(MODE_PACKET, pkt_bytes[i], i == pkt_bytes.size() - 1);
    end
  endtask

  task automatic test_store_load();
    repeat (5) send_item(MODE_LOAD, 8'($urandom), 1'b0);
    send_item(MODE_LOAD, 8'hff, 1'b1);
    send_item(MODE_LOAD, 8'h00, 1'b0);
    repeat (STORE_BYTES - 1) send_item(MODE_LOAD, 8'($urandom), 1'b0);
  endtask

  task automatic test_header_checks();
    start_packet(8'd0, 8'd1);
    add_tail(TAIL_NEED);
    send_packet();
    start_packet(8'd1, 8'd1);
    add_tail(TAIL_NEED);
    send_packet();
    start_packet(8'd0, 8'd0);
    add_tail(TAIL_NEED);
    send_packet();
    start_packet(8'hff, 8'hff);
    add_tail(TAIL_NEED);
    send_packet();
    start_packet(8'd0, 8'd1);
    cut_packet(7);
    send_packet();
    start_packet(8'd0, 8'd1);
    cut_packet(1);
    send_packet();
  endtask

  task automatic test_label_bounds();
    start_packet(8'd0, 8'd1);
    pkt_bytes.push_back(8'd12);
    pkt_bytes.push_back(UPPER_A);
    pkt_bytes.push_back(UPPER_Z);
    pkt_bytes.push_back(LOWER_A);
    pkt_bytes.push_back(LOWER_Z);
    pkt_bytes.push_back(UPPER_A - 8'd1);
    pkt_bytes.push_back(UPPER_Z + 8'd1);
    pkt_bytes.push_back(LOWER_A - 8'd1);
    pkt_bytes.push_back(LOWER_Z + 8'd1);
    pkt_bytes.push_back(8'h30);
    pkt_bytes.push_back(8'h00);
    pkt_bytes.push_back(8'hff);
    pkt_bytes.push_back(8'hc1);
    add_label(MAX_LABEL);
    add_tail(TAIL_NEED);
    send_packet();
    start_packet(8'd0, 8'd1);
    pkt_bytes.push_back(MAX_LABEL + 8'd1);
    add_tail(TAIL_NEED);
    send_packet();
    start_packet(8'd0, 8'd1);
    add_label(2);
    pkt_bytes.push_back(8'hff);
    add_tail(TAIL_NEED);
    send_packet();
  endtask

  task automatic test_truncation();
    start_packet(8'd0, 8'd1);
    add_label(3);
    send_packet();
    start_packet(8'd0, 8'd1);
    add_label(6);
    cut_packet(pkt_bytes.size() - 2);
    send_packet();
    start_packet(8'd0, 8'd1);
    add_label(2);
    add_tail(0);
    send_packet();
    start_packet(8'd0, 8'd1);
    add_label(2);
    add_tail(TAIL_NEED - 1);
    send_packet();
  endtask

  task automatic test_bit_exhaustion();
    letter_pct = 100;
    for (int extra = 4; extra <= 5; extra++) begin
      start_packet(8'd0, 8'd1);
      repeat (4) add_label(MAX_LABEL);
      add_label(extra);
      add_label(3);
      add_tail(TAIL_NEED);
      send_packet();
    end
    letter_pct = 50;
  endtask

  task automatic test_drain_pause();
    start_packet(8'd0, 8'd1);
    add_label(8);
    add_tail(TAIL_NEED);
    send_packet();
    in_valid <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
    start_packet(8'd0, 8'd1);
    add_label(5);
    add_tail(TAIL_NEED + 1);
    send_packet();
  endtask

  task automatic build_good_packet();
    start_packet(8'd0, 8'd1);
    repeat ($urandom_range(1, 4)) begin
      add_label($urandom_range(0, 9) == 0 ? $urandom_range(1, MAX_LABEL) : $urandom_range(1, 12));
    end
    add_tail($urandom_range(TAIL_NEED, 8));
  endtask

  task automatic test_random_traffic();
    int first;
    int kind;
    logic [7:0] hi;
    logic [7:0] lo;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      if (items_sent - first >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      tx_gap_pct = $urandom_range(0, 2) == 0 ? 0 : 30;
      rx_stalls = $urandom_range(0, 2) != 0;
      mix_loads = $urandom_range(0, 3) == 0;
      letter_pct = $urandom_range(0, 100);
      kind = $urandom_range(0, 19);
      case (kind)
        0: begin
          hi = 8'($urandom);
          lo = 8'($urandom);
          if (hi == 8'd0 && lo == 8'd1) lo = 8'd2;
          start_packet(hi, lo);
          add_label($urandom_range(1, 8));
          add_tail(TAIL_NEED);
        end
        1: begin
          start_packet(8'd0, 8'd1);
          add_label($urandom_range(1, 8));
          pkt_bytes.push_back(8'($urandom_range(MAX_LABEL + 1, 255)));
          add_tail(TAIL_NEED);
        end
        2: begin
          build_good_packet();
          cut_packet($urandom_range(1, pkt_bytes.size() - 1));
        end
        3: begin
          start_packet(8'd0, 8'd1);
          add_label($urandom_range(1, 10));
          add_tail($urandom_range(0, TAIL_NEED - 1));
        end
        4: begin
          pkt_bytes.delete();
          repeat ($urandom_range(1, 40)) begin
            send_item(MODE_LOAD, 8'($urandom), 1'($urandom_range(0, 7) == 0));
          end
        end
        5: begin
          pkt_bytes.delete();
          repeat ($urandom_range(1, 20)) pkt_bytes.push_back(8'($urandom));
        end
        default: build_good_packet();
      endcase
      send_packet();
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    tx_gap_pct = 25;
    rx_stalls = 1'b1;
    test_store_load();
    test_header_checks();
    test_label_bounds();
    test_truncation();
    test_bit_exhaustion();
    test_drain_pause();
    test_random_traffic();
    in_valid <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
